// ===== rtl/hlc_pkg.sv =====
// Shared types, codes and constants of the hashed lookup cache.
package hlc_pkg;

   localparam int unsigned DEF_SLOTS     = 128;
   localparam int unsigned DEF_NAME_CAP  = 64;
   localparam int unsigned DEF_NODE_BITS = 32;
   localparam int unsigned HASH_MUL      = 131;
   localparam int unsigned SEED_SHIFT    = 4;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_FILL_POS = 2'd1,
      OP_FILL_NEG = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_MISS = 2'd0,
      ST_POS  = 2'd1,
      ST_NEG  = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] parent_node;
      logic [31:0] child_node;
      logic [7:0]  name_byte;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] child_node_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        cacheable;
      logic [31:0] parent;
      logic [31:0] child;
      logic [31:0] hash;
      logic [7:0]  count;
      logic        bank;
   } job_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [7:0] pos;
      logic [7:0] data;
   } nbw_type;

   typedef struct packed {
      logic [31:0] parent;
      logic [31:0] child;
      logic [31:0] hash;
      logic [7:0]  len;
   } meta_type;

endpackage

// ===== rtl/hlc_queue.sv =====
// Two-entry job queue between the front and the back of the cache.
module hlc_queue
   import hlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/hlc_front.sv =====
// Front end: takes name bytes, extends the hash and hands finished names on as jobs.
module hlc_front
   import hlc_pkg::*;
#(
   parameter int unsigned NAME_CAP  = DEF_NAME_CAP,
   parameter int unsigned NODE_BITS = DEF_NODE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    clear_done,
   input  logic    q_full,
   output logic    push,
   output job_type push_job,
   output nbw_type nbw
);

   localparam int unsigned CW = $clog2(NAME_CAP + 1);
   localparam int unsigned PB = (NODE_BITS < 32) ? NODE_BITS : 32;
   localparam logic [31:0] PMASK = (PB >= 32) ? 32'hFFFF_FFFF :
                                   32'((64'd1 << PB) - 64'd1);

   logic [31:0]   hash_ff, hash_in;
   logic [CW-1:0] count_ff, count_in;
   logic          tl_ff, tl_in;
   logic          bank_ff, bank_in;

   logic          accept, live, store, cacheable;
   logic [31:0]   parent_m, seed, hash_new;
   logic [CW-1:0] count_new;
   logic          tl_new;

   always_comb begin
      req_ready = clear_done && !q_full;
      accept    = req_valid && req_ready;
      parent_m  = req_payload.parent_node & PMASK;
      live      = accept && (parent_m != 32'd0);
      seed      = ((count_ff == '0) && !tl_ff) ? (parent_m >> SEED_SHIFT) : hash_ff;
      hash_new  = (seed << 7) + (seed << 1) + seed + {24'd0, req_payload.name_byte};
      store     = !tl_ff && (count_ff < CW'(NAME_CAP));
      count_new = store ? count_ff + CW'(1) : count_ff;
      tl_new    = tl_ff || !store;
      cacheable = !tl_new && (count_new < CW'(NAME_CAP));

      push = live && req_payload.last &&
             ((req_payload.op == OP_LOOKUP) ||
              (cacheable && (((req_payload.op == OP_FILL_POS) &&
                              (req_payload.child_node != 32'd0)) ||
                             (req_payload.op == OP_FILL_NEG))));

      push_job.op        = req_payload.op;
      push_job.cacheable = cacheable;
      push_job.parent    = parent_m;
      push_job.child     = (req_payload.op == OP_FILL_POS) ? req_payload.child_node : 32'd0;
      push_job.hash      = hash_new;
      push_job.count     = 8'(count_new);
      push_job.bank      = bank_ff;

      nbw.en   = live && store;
      nbw.bank = bank_ff;
      nbw.pos  = 8'(count_ff);
      nbw.data = req_payload.name_byte;

      hash_in  = hash_ff;
      count_in = count_ff;
      tl_in    = tl_ff;
      bank_in  = push ? ~bank_ff : bank_ff;
      if (live) begin
         if (req_payload.last) begin
            hash_in  = 32'd0;
            count_in = '0;
            tl_in    = 1'b0;
         end else begin
            hash_in  = hash_new;
            count_in = count_new;
            tl_in    = tl_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= 32'd0;
         count_ff <= '0;
         tl_ff    <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
         tl_ff    <= tl_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// ===== rtl/hlc_back.sv =====
// Back end: slot selection, stored-name compare, slot fills and the response register.
module hlc_back
   import hlc_pkg::*;
#(
   parameter int unsigned SLOTS    = DEF_SLOTS,
   parameter int unsigned NAME_CAP = DEF_NAME_CAP
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   input  nbw_type nbw,
   output logic    clear_done,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int unsigned SB      = $clog2(SLOTS);
   localparam int unsigned PW      = (NAME_CAP > 2) ? $clog2(NAME_CAP) : 1;
   localparam bit          POW2    = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [63:0] RECIP   = ((64'd1 << (32 + SB)) + 64'(SLOTS) - 64'd1) /
                                     64'(SLOTS);
   localparam logic [32:0] RECIP_M = RECIP[32:0];

   typedef enum logic [6:0] {
      B_CLEAR = 7'b0000001,
      B_IDLE  = 7'b0000010,
      B_MOD   = 7'b0000100,
      B_META  = 7'b0001000,
      B_CMP   = 7'b0010000,
      B_COPY  = 7'b0100000,
      B_RESP  = 7'b1000000
   } bstate_type;

   meta_type   meta_mem [SLOTS];
   logic [7:0] name_mem [SLOTS][NAME_CAP];
   logic [7:0] nb_mem [2][NAME_CAP];

   bstate_type  state_ff, state_in;
   logic [SB-1:0] clr_ff, clr_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [1:0]    step_ff, step_in;
   logic [64:0]   prod_ff, prod_in;
   logic [8:0]    pos_ff, pos_in;
   logic          match_ff, match_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   meta_type      meta_rd_ff;
   logic [7:0]    nm_rd_ff, nb_rd_ff;

   logic          meta_we, meta_re, name_we;
   logic [SB-1:0] meta_wa;
   meta_type      meta_wd;
   logic [8:0]    rd_pos;
   logic [15:0]   half;
   logic [48:0]   part;
   logic [31:0]   quot;
   logic [SB-1:0] mod_slot;
   logic          hit;

   assign clear_done  = (state_ff != B_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      pos_in       = pos_ff;
      match_in     = match_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      meta_we      = 1'b0;
      meta_re      = 1'b0;
      name_we      = 1'b0;
      meta_wa      = slot_ff;
      meta_wd.parent = job.parent;
      meta_wd.child  = job.child;
      meta_wd.hash   = job.hash;
      meta_wd.len    = job.count;
      rd_pos       = 9'd0;
      half         = (step_ff == 2'd0) ? job.hash[15:0] : job.hash[31:16];
      part         = {33'd0, half} * {16'd0, RECIP_M};
      quot         = 32'(prod_ff >> (32 + SB));
      mod_slot     = job.hash[SB-1:0] - SB'(quot[SB-1:0] * SB'(SLOTS));
      hit = match_ff && (meta_rd_ff.parent == job.parent) &&
            (meta_rd_ff.hash == job.hash) && (meta_rd_ff.len == job.count);

      case (state_ff)
         B_CLEAR: begin
            meta_we        = 1'b1;
            meta_wa        = clr_ff;
            meta_wd.parent = 32'd0;
            clr_in         = clr_ff + SB'(1);
            if (clr_ff == SB'(SLOTS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (job_valid) begin
               if (POW2) begin
                  slot_in  = job.hash[SB-1:0];
                  state_in = B_META;
               end else begin
                  step_in  = 2'd0;
                  state_in = B_MOD;
               end
            end
         end
         B_MOD: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd0) begin
               prod_in = {16'd0, part};
            end else if (step_ff == 2'd1) begin
               prod_in = prod_ff + {part, 16'd0};
            end else begin
               slot_in  = mod_slot;
               state_in = B_META;
            end
         end
         B_META: begin
            pos_in = 9'd0;
            if (job.op == OP_LOOKUP) begin
               if (!job.cacheable) begin
                  res_in.status         = ST_MISS;
                  res_in.child_node_out = 32'd0;
                  state_in              = B_RESP;
               end else begin
                  meta_re  = 1'b1;
                  match_in = 1'b1;
                  state_in = B_CMP;
               end
            end else begin
               meta_we  = 1'b1;
               state_in = B_COPY;
            end
         end
         B_CMP: begin
            if (pos_ff < {1'b0, job.count}) begin
               if (nm_rd_ff != nb_rd_ff) begin
                  match_in = 1'b0;
               end
               pos_in = pos_ff + 9'd1;
               rd_pos = pos_ff + 9'd1;
            end else begin
               if (hit && (meta_rd_ff.child != 32'd0)) begin
                  res_in.status         = ST_POS;
                  res_in.child_node_out = meta_rd_ff.child;
               end else if (hit) begin
                  res_in.status         = ST_NEG;
                  res_in.child_node_out = 32'd0;
               end else begin
                  res_in.status         = ST_MISS;
                  res_in.child_node_out = 32'd0;
               end
               state_in = B_RESP;
            end
         end
         B_COPY: begin
            name_we = 1'b1;
            pos_in  = pos_ff + 9'd1;
            rd_pos  = pos_ff + 9'd1;
            if (pos_ff == {1'b0, job.count} - 9'd1) begin
               job_pop  = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               job_pop      = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      pos_ff      <= pos_in;
      match_ff    <= match_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (meta_re) begin
         meta_rd_ff <= meta_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[slot_ff][pos_ff[PW-1:0]] <= nb_rd_ff;
      end
      nm_rd_ff <= name_mem[slot_ff][rd_pos[PW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (nbw.en) begin
         nb_mem[nbw.bank][nbw.pos[PW-1:0]] <= nbw.data;
      end
      nb_rd_ff <= nb_mem[job.bank][rd_pos[PW-1:0]];
   end

endmodule

// ===== rtl/hashed_lookup_cache_with_negatives_top.sv =====
// Top level of the direct-mapped name lookup cache with negative entries.
// Requests carry one name byte each, with the parent id, operation and child id;
// the byte flagged last closes the name and triggers a lookup or a fill.
// The front takes one request per cycle while the queue is not full and extends
// the running hash. Each closed name becomes a job in a two-entry queue, so the
// front keeps taking the bytes of the next name while the back works on the
// previous one. A lookup with a nonzero parent id answers with one response of
// status and child id; fills and intermediate bytes give none. In the back, a
// lookup compares the stored name and a fill copies it, one byte at a time; when
// SLOTS is not a power of two, the hash is first reduced modulo SLOTS to a slot.
// After reset the back clears every slot, one per cycle, and no request is
// taken during that sweep.
// A stalled receiver holds the response register; the back then waits with its
// job while the queue and the front keep filling until the queue is full.
module hashed_lookup_cache_with_negatives_top
   import hlc_pkg::*;
#(
   parameter int unsigned SLOTS     = DEF_SLOTS,
   parameter int unsigned NAME_CAP  = DEF_NAME_CAP,
   parameter int unsigned NODE_BITS = DEF_NODE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    clear_done, q_full, push, head_valid, job_pop;
   job_type push_job, head_job;
   nbw_type nbw;

   hlc_front #(
      .NAME_CAP  (NAME_CAP),
      .NODE_BITS (NODE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .clear_done  (clear_done),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job),
      .nbw         (nbw)
   );

   hlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop)
   );

   hlc_back #(
      .SLOTS    (SLOTS),
      .NAME_CAP (NAME_CAP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head_job),
      .job_pop     (job_pop),
      .nbw         (nbw),
      .clear_done  (clear_done),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
